FILE: rtl/pkat_pkg.sv
package pkat_pkg;

	// Field widths
	localparam int MEAS_W   = 16;
	localparam int REQ_W    = 16;
	localparam int TARGET_W = 15;
	localparam int DB_W     = 12;
	localparam int LIM_W    = 13;
	localparam int INTV_W   = 16;
	localparam int CORR_W   = 14;

	// APB address and data widths
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// Measurements at or below this level are not used for tuning
	localparam logic [MEAS_W-1:0] VALID_MEAS_MV = MEAS_W'(1000);

	// Requests are truncated to multiples of this step when auto tuning is on
	localparam int STEP_MV = 20;

	// Divide by 5 through a reciprocal: floor(y * 13108 / 2^16) is exact for y < 16384
	localparam int DIV5_W = 14;
	localparam logic [DIV5_W-1:0] DIV5_RECIP = DIV5_W'(13108);
	localparam int DIV5_SHIFT = 16;

	// Register indexes (byte address is four times the index)
	typedef enum logic [2:0] {
		REG_AUTO_TUNE   = 3'd0,
		REG_TARGET      = 3'd1,
		REG_DEADBAND    = 3'd2,
		REG_MAX_CORR    = 3'd3,
		REG_RANGE_MIN   = 3'd4,
		REG_RANGE_MAX   = 3'd5,
		REG_REFRESH     = 3'd6
	} reg_idx_t;

	// Register contents handed to the datapath
	typedef struct packed {
		logic                auto_tune_enable;
		logic [TARGET_W-1:0] target_mv;
		logic [DB_W-1:0]     deadband_mv;
		logic [LIM_W-1:0]    max_correction_mv;
		logic [TARGET_W-1:0] range_min_mv;
		logic [TARGET_W-1:0] range_max_mv;
		logic [INTV_W-1:0]   refresh_interval_ticks;
	} cfg_t;

endpackage

FILE: rtl/pkat_regs.sv
module pkat_regs
	import pkat_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	// Write the addressed register, keeping only its low bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_tune_enable       <= 1'b0;
			cfg_q.target_mv              <= '0;
			cfg_q.deadband_mv            <= '0;
			cfg_q.max_correction_mv      <= '0;
			cfg_q.range_min_mv           <= '0;
			cfg_q.range_max_mv           <= '0;
			cfg_q.refresh_interval_ticks <= INTV_W'(1);
		end else if (wr_en) begin
			unique case (idx)
				REG_AUTO_TUNE: cfg_q.auto_tune_enable       <= pwdata[0];
				REG_TARGET:    cfg_q.target_mv              <= pwdata[TARGET_W-1:0];
				REG_DEADBAND:  cfg_q.deadband_mv            <= pwdata[DB_W-1:0];
				REG_MAX_CORR:  cfg_q.max_correction_mv      <= pwdata[LIM_W-1:0];
				REG_RANGE_MIN: cfg_q.range_min_mv           <= pwdata[TARGET_W-1:0];
				REG_RANGE_MAX: cfg_q.range_max_mv           <= pwdata[TARGET_W-1:0];
				REG_REFRESH:   cfg_q.refresh_interval_ticks <= pwdata[INTV_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (idx)
			REG_AUTO_TUNE: prdata = APB_DW'(cfg_q.auto_tune_enable);
			REG_TARGET:    prdata = APB_DW'(cfg_q.target_mv);
			REG_DEADBAND:  prdata = APB_DW'(cfg_q.deadband_mv);
			REG_MAX_CORR:  prdata = APB_DW'(cfg_q.max_correction_mv);
			REG_RANGE_MIN: prdata = APB_DW'(cfg_q.range_min_mv);
			REG_RANGE_MAX: prdata = APB_DW'(cfg_q.range_max_mv);
			REG_REFRESH:   prdata = APB_DW'(cfg_q.refresh_interval_ticks);
			default:       prdata = '0;
		endcase
	end

endmodule

FILE: rtl/pps_keepalive_auto_tuner_unit.sv
// Keep-alive voltage requester with integral auto tuning. Feed one tick item per
// millisecond on the s_ stream (tdata = measured mV, tuser = restart); every
// refresh interval a request item leaves on the m_ stream (tdata = requested mV,
// tuser = converged flag). Ticks that do not reach the interval, ticks with a
// zero target and restart ticks give no item. The unit takes one item per clock
// while s_tready is high; a request passes the input register, the tuning stage
// (correction and tick count update), then, with tuning on, the range clamp and
// 20 mV truncation into the output register. s_tready only drops while a
// request waits on m_tready. Program registers over APB while the stream is
// idle; register writes never clear the tuning state.
module pps_keepalive_auto_tuner_unit
	import pkat_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// APB register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	// Tick items
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // [15:0] vout_mv
	input  logic [0:0]        s_tuser,   // [0] restart
	// Request items
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // [15:0] req_volt_mv
	output logic [0:0]        m_tuser    // [0] converged
);

	cfg_t cfg;

	pkat_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Pipeline and state registers
	logic                     valid_s1;
	logic [MEAS_W-1:0]        meas_s1;
	logic                     restart_s1;

	logic signed [CORR_W-1:0] corr_q;
	logic                     conv_q;
	logic [INTV_W-1:0]        ticks_q;

	logic                     valid_s2;
	logic                     auto_s2;
	logic signed [16:0]       adj_s2;
	logic                     conv_s2;

	logic                     out_valid_q;
	logic [REQ_W-1:0]         out_req_q;
	logic                     out_conv_q;

	// Handshake
	logic out_ready;
	logic s2_ready;
	logic fire_s1;

	assign out_ready = !out_valid_q || m_tready;
	assign s2_ready  = !valid_s2 || out_ready;
	assign s_tready  = !valid_s1 || s2_ready;
	assign fire_s1   = valid_s1 && s2_ready;

	// Tuning stage logic
	logic [INTV_W-1:0]        ticks_inc;
	logic                     emit_s1;
	logic                     tune_s1;
	logic signed [17:0]       err;
	logic signed [17:0]       err_neg;
	logic [16:0]              mag;
	logic                     outside;
	logic signed [18:0]       sum;
	logic signed [18:0]       lim;
	logic signed [CORR_W-1:0] corr_clamped;
	logic signed [CORR_W-1:0] corr_new;
	logic                     conv_new;
	logic signed [16:0]       adj;

	always_comb begin
		ticks_inc = (ticks_q == '1) ? ticks_q : ticks_q + INTV_W'(1);
		emit_s1   = !restart_s1 && (cfg.target_mv != '0)
			&& (ticks_inc >= cfg.refresh_interval_ticks);
		tune_s1   = emit_s1 && cfg.auto_tune_enable && (meas_s1 > VALID_MEAS_MV);

		// error and its magnitude
		err     = $signed({3'b000, cfg.target_mv}) - $signed({2'b00, meas_s1});
		err_neg = -err;
		mag     = err[17] ? err_neg[16:0] : err[16:0];
		outside = mag > {5'b00000, cfg.deadband_mv};

		// saturating correction
		sum = 19'(corr_q) + 19'(err);
		lim = $signed({6'b000000, cfg.max_correction_mv});
		if (sum > lim) begin
			corr_clamped = CORR_W'(lim);
		end else if (sum < -lim) begin
			corr_clamped = CORR_W'(-lim);
		end else begin
			corr_clamped = CORR_W'(sum);
		end

		corr_new = corr_q;
		conv_new = conv_q;
		if (tune_s1) begin
			if (outside) begin
				corr_new = corr_clamped;
				conv_new = 1'b0;
			end else begin
				conv_new = 1'b1;
			end
		end

		// adjusted voltage, or plain target with tuning off
		if (cfg.auto_tune_enable) begin
			adj = $signed({2'b00, cfg.target_mv}) + 17'(corr_new);
		end else begin
			adj = $signed({2'b00, cfg.target_mv});
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			meas_s1    <= s_tdata[MEAS_W-1:0];
			restart_s1 <= s_tuser[0];
		end
	end

	// Tuning state: advance as each item leaves the tuning stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corr_q  <= '0;
			conv_q  <= 1'b0;
			ticks_q <= '0;
		end else if (fire_s1) begin
			if (restart_s1) begin
				corr_q  <= '0;
				conv_q  <= 1'b0;
				ticks_q <= '0;
			end else begin
				corr_q  <= corr_new;
				conv_q  <= conv_new;
				ticks_q <= emit_s1 ? '0 : ticks_inc;
			end
		end
	end

	// Second stage: hold adjusted voltage for shaping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= fire_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready) begin
			auto_s2 <= cfg.auto_tune_enable;
			adj_s2  <= adj;
			conv_s2 <= conv_new;
		end
	end

	// Shaping (tuning on): range clamp, floor at zero, truncate to the 20 mV step
	logic signed [16:0]          ranged;
	logic [DIV5_W-1:0]           quarter;
	logic [2*DIV5_W-1:0]         prod;
	logic [REQ_W-1:0]            quot;
	logic [REQ_W-1:0]            req;

	always_comb begin
		ranged = adj_s2;
		if (cfg.range_max_mv != '0) begin
			if (ranged < $signed({2'b00, cfg.range_min_mv})) begin
				ranged = $signed({2'b00, cfg.range_min_mv});
			end
			if (ranged > $signed({2'b00, cfg.range_max_mv})) begin
				ranged = $signed({2'b00, cfg.range_max_mv});
			end
		end

		// x / 20 = (x >> 2) / 5
		quarter = ranged[15:2];
		prod    = quarter * DIV5_RECIP;
		quot    = REQ_W'(prod[2*DIV5_W-1:DIV5_SHIFT]);

		if (!auto_s2) begin
			req = adj_s2[REQ_W-1:0];
		end else if (ranged[16]) begin
			req = '0;
		end else begin
			req = quot * REQ_W'(STEP_MV);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s2) begin
			out_req_q  <= req;
			out_conv_q <= conv_s2;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_req_q;
	assign m_tuser[0] = out_conv_q;

endmodule

FILE: rtl/pkat_checker.sv
module pkat_checker
	import pkat_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// With no request waiting, the unit always takes a tick
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("tick input stalled with output empty");

	// Requests never exceed 40960 mV
	a_request_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata <= 16'd40960))
		else $error("request voltage out of range");

	// A stalled request holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("request changed while stalled");

	// Register port never inserts wait states
	a_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind pps_keepalive_auto_tuner_unit pkat_checker u_pkat_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pready   (pready),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

FILE: tb/tb_pps_keepalive_auto_tuner_unit.sv
module tb_pps_keepalive_auto_tuner_unit;
	import pkat_pkg::*;

	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_OFF_CYCLES = 500;
	localparam int STALL_LIMIT     = 4000;
	localparam int NUM_PHASES      = 9;
	localparam int PHASE_ITEMS     = 145;
	localparam int DIRECTED_ROWS   = 39;

	typedef struct packed {
		logic [REQ_W-1:0] req_volt_mv;
		logic             converged;
	} request_t;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;
	typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_mode_t;

	typedef struct packed {
		row_kind_t   kind;
		reg_idx_t    idx;
		logic [31:0] value;   // register value, or measured mV for a tick
		logic        restart;
		logic        typed;   // 1: expect the request below instead of the predicted one
		request_t    want;
	} directed_row_t;

	localparam request_t NO_REQ = '{16'd0, 1'b0};

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              s_tvalid;
	logic              s_tready;
	logic [15:0]       s_tdata;   // [15:0] vout_mv
	logic [0:0]        s_tuser;   // [0] restart
	logic              m_tvalid;
	logic              m_tready;
	logic [15:0]       m_tdata;   // [15:0] req_volt_mv
	logic [0:0]        m_tuser;   // [0] converged

	// Shadow of the tuner: registers and tuning state
	cfg_t              tuner_cfg;
	int                corr_mv;
	logic              conv_flag;
	logic [INTV_W-1:0] tick_count;

	request_t pending_requests[$];
	int       mismatches = 0;
	int       quiet_cycles = 0;
	int       hold_off_reqs = 0;

	// Ticks: restart, thresholds, clamps, negative request, deadband edges, auto off
	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{ROW_TICK,  REG_AUTO_TUNE, 32'd0,     1'b0, 1'b0, NO_REQ},
		'{ROW_WRITE, REG_TARGET,    32'd5000,  1'b0, 1'b0, NO_REQ},
		'{ROW_TICK,  REG_AUTO_TUNE, 32'd65535, 1'b0, 1'b1, '{16'd5000, 1'b0}},
		'{ROW_WRITE, REG_REFRESH,   32'd0,     1'b0, 1'b0, NO_REQ},
		'{ROW_TICK,  REG_AUTO_TUNE, 32'd1234,  1'b0, 1'b1, '{16'd5000, 1'b0}},
		'{ROW_WRITE, REG_AUTO_TUNE, 32'd1,     1'b0, 1'b0, NO_REQ},
		'{ROW_WRITE, REG_DEADBAND,  32'd100,   1'b0, 1'b0, NO_REQ},
		'{ROW_WRITE, REG_MAX_CORR,  32'd8191,  1'b0, 1'b0, NO_REQ},
		'{ROW_TICK,  REG_AUTO_TUNE, 32'd1000,  1'b0, 1'b1, '{16'd5000, 1'b0}},
		'{ROW_TICK,  REG_AUTO_TUNE, 32'd1001,  1'b0, 1'b1, '{16'd8980, 1'b0}},
		'{ROW_TICK,  REG_AUTO_TUNE, 32'd5050,  1'b0, 1'b1, '{16'd8980, 1'b1}},
		'{ROW_TICK,  REG_AUTO_TUNE, 32'd65535, 1'b0, 1'b1, '{16'd0, 1'b0}},
		'{ROW_TICK,  REG_AUTO_TUNE, 32'd0,     1'b1, 1'b0, NO_REQ},
		'{ROW_TICK,  REG_AUTO_TUNE, 32'd5000,  1'b0, 1'b1, '{16'd5000, 1'b1}},
		'{ROW_WRITE, REG_RANGE_MAX, 32'd7000,  1'b0, 1'b0, NO_REQ},
		'{ROW_WRITE, REG_RANGE_MIN, 32'd6000,  1'b0, 1'b0, NO_REQ},
		'{ROW_TICK,  REG_AUTO_TUNE, 32'd5000,  1'b0, 1'b1, '{16'd6000, 1'b1}},
		'{ROW_WRITE, REG_RANGE_MIN, 32'd9000,  1'b0, 1'b0, NO_REQ},
		'{ROW_TICK,  REG_AUTO_TUNE, 32'd4950,  1'b0, 1'b1, '{16'd7000, 1'b1}},
		'{ROW_WRITE, REG_RANGE_MAX, 32'd0,     1'b0, 1'b0, NO_REQ},
		'{ROW_WRITE, REG_RANGE_MIN, 32'd32767, 1'b0, 1'b0, NO_REQ},
		'{ROW_WRITE, REG_TARGET,    32'd32767, 1'b0, 1'b0, NO_REQ},
		'{ROW_WRITE, REG_DEADBAND,  32'd4095,  1'b0, 1'b0, NO_REQ},
		'{ROW_TICK,  REG_AUTO_TUNE, 32'd24576, 1'b0, 1'b1, '{16'd40940, 1'b0}},
		'{ROW_TICK,  REG_AUTO_TUNE, 32'd28672, 1'b0, 1'b1, '{16'd40940, 1'b1}},
		'{ROW_TICK,  REG_AUTO_TUNE, 32'd28671, 1'b0, 1'b1, '{16'd40940, 1'b0}},
		'{ROW_WRITE, REG_AUTO_TUNE, 32'd0,     1'b0, 1'b0, NO_REQ},
		'{ROW_TICK,  REG_AUTO_TUNE, 32'd1001,  1'b0, 1'b1, '{16'd32767, 1'b0}},
		'{ROW_WRITE, REG_AUTO_TUNE, 32'd1,     1'b0, 1'b0, NO_REQ},
		'{ROW_WRITE, REG_MAX_CORR,  32'd0,     1'b0, 1'b0, NO_REQ},
		'{ROW_WRITE, REG_DEADBAND,  32'd0,     1'b0, 1'b0, NO_REQ},
		'{ROW_WRITE, REG_TARGET,    32'd39,    1'b0, 1'b0, NO_REQ},
		'{ROW_TICK,  REG_AUTO_TUNE, 32'd65535, 1'b0, 1'b1, '{16'd20, 1'b0}},
		'{ROW_WRITE, REG_REFRESH,   32'd3,     1'b0, 1'b0, NO_REQ},
		'{ROW_TICK,  REG_AUTO_TUNE, 32'd2000,  1'b0, 1'b0, NO_REQ},
		'{ROW_TICK,  REG_AUTO_TUNE, 32'd2000,  1'b0, 1'b0, NO_REQ},
		'{ROW_TICK,  REG_AUTO_TUNE, 32'd2000,  1'b0, 1'b0, NO_REQ},
		'{ROW_TICK,  REG_AUTO_TUNE, 32'd65535, 1'b1, 1'b0, NO_REQ},
		'{ROW_TICK,  REG_AUTO_TUNE, 32'd1,     1'b0, 1'b0, NO_REQ}
	};

	pps_keepalive_auto_tuner_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Advance the tuner shadow by one tick; return 1 when a request is due
	function automatic bit tune_tick(input logic [MEAS_W-1:0] meas, input logic restart,
			output request_t req);
		int err;
		int lim;
		int adj;
		req = '0;
		if (restart) begin
			corr_mv    = 0;
			conv_flag  = 1'b0;
			tick_count = '0;
			return 1'b0;
		end
		if (tick_count != '1)
			tick_count++;
		if (tuner_cfg.target_mv == '0 || tick_count < tuner_cfg.refresh_interval_ticks)
			return 1'b0;
		tick_count = '0;
		if (!tuner_cfg.auto_tune_enable) begin
			req.req_volt_mv = REQ_W'(tuner_cfg.target_mv);
		end else begin
			lim = int'(tuner_cfg.max_correction_mv);
			// Integrate errors outside the deadband, only for valid measurements
			if (meas > VALID_MEAS_MV) begin
				err = int'(tuner_cfg.target_mv) - int'(meas);
				if ((err < 0 ? -err : err) > int'(tuner_cfg.deadband_mv)) begin
					corr_mv = corr_mv + err;
					if (corr_mv > lim)
						corr_mv = lim;
					if (corr_mv < -lim)
						corr_mv = -lim;
					conv_flag = 1'b0;
				end else begin
					conv_flag = 1'b1;
				end
			end
			// Clamp to the profile range (max wins), then round down to the step
			adj = int'(tuner_cfg.target_mv) + corr_mv;
			if (tuner_cfg.range_max_mv != '0) begin
				if (adj < int'(tuner_cfg.range_min_mv))
					adj = int'(tuner_cfg.range_min_mv);
				if (adj > int'(tuner_cfg.range_max_mv))
					adj = int'(tuner_cfg.range_max_mv);
			end
			req.req_volt_mv = (adj < 0) ? '0 : REQ_W'((adj / STEP_MV) * STEP_MV);
		end
		req.converged = conv_flag;
		return 1'b1;
	endfunction

	// Random register value, sometimes with junk above the register width
	function automatic logic [APB_DW-1:0] pick_reg_value(input reg_idx_t idx);
		int unsigned v;
		int unsigned w;
		v = 0;
		w = 1;
		case (idx)
			REG_AUTO_TUNE: begin
				v = ($urandom_range(0, 3) != 0);
				w = 1;
			end
			REG_TARGET: begin
				case ($urandom_range(0, 9))
					0: v = 0;
					1: v = 32767;
					2: v = $urandom_range(1, 32767);
					default: v = $urandom_range(3000, 21000);
				endcase
				w = TARGET_W;
			end
			REG_DEADBAND: begin
				case ($urandom_range(0, 7))
					0: v = 0;
					1: v = 4095;
					default: v = $urandom_range(0, 300);
				endcase
				w = DB_W;
			end
			REG_MAX_CORR: begin
				case ($urandom_range(0, 7))
					0: v = 0;
					1: v = 8191;
					default: v = $urandom_range(0, 3000);
				endcase
				w = LIM_W;
			end
			REG_RANGE_MIN: begin
				case ($urandom_range(0, 7))
					0: v = 0;
					1: v = 32767;
					default: v = $urandom_range(3000, 21000);
				endcase
				w = TARGET_W;
			end
			REG_RANGE_MAX: begin
				case ($urandom_range(0, 7))
					0, 1: v = 0;
					2: v = 32767;
					default: v = $urandom_range(3000, 21000);
				endcase
				w = TARGET_W;
			end
			REG_REFRESH: begin
				case ($urandom_range(0, 9))
					0: v = 0;
					1: v = 1;
					2: v = $urandom_range(5, 40);
					default: v = $urandom_range(1, 4);
				endcase
				w = INTV_W;
			end
			default: ;
		endcase
		if ($urandom_range(0, 3) == 0)
			v = v | ($urandom << w);
		return v;
	endfunction

	// Write one register through setup and access, then mirror it
	task automatic apb_write(input reg_idx_t idx, input logic [APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		case (idx)
			REG_AUTO_TUNE: tuner_cfg.auto_tune_enable       = value[0];
			REG_TARGET:    tuner_cfg.target_mv              = value[TARGET_W-1:0];
			REG_DEADBAND:  tuner_cfg.deadband_mv            = value[DB_W-1:0];
			REG_MAX_CORR:  tuner_cfg.max_correction_mv      = value[LIM_W-1:0];
			REG_RANGE_MIN: tuner_cfg.range_min_mv           = value[TARGET_W-1:0];
			REG_RANGE_MAX: tuner_cfg.range_max_mv           = value[TARGET_W-1:0];
			REG_REFRESH:   tuner_cfg.refresh_interval_ticks = value[INTV_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Offer one tick item and hold it until taken; record the request it causes
	task automatic send_tick(input logic [MEAS_W-1:0] meas, input logic restart,
			input logic typed, input request_t typed_req);
		request_t predicted;
		s_tvalid <= 1'b1;
		s_tdata  <= meas;
		s_tuser  <= restart;
		do @(posedge clk); while (s_tready !== 1'b1);
		if (tune_tick(meas, restart, predicted))
			pending_requests.push_back(typed ? typed_req : predicted);
		@(negedge clk);
	endtask

	// Stop offering, wait for every request, then let the pipeline empty
	task automatic drain_stream();
		s_tvalid <= 1'b0;
		while (pending_requests.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Ticks in bursts; most measurements hover around the target to reach convergence
	task automatic send_random_ticks(input int count, input bit bursty, input bit with_restart);
		int                burst_left;
		int                gap;
		int                level;
		int                db;
		logic [MEAS_W-1:0] meas;
		logic              restart;
		burst_left = 0;
		for (int n = 0; n < count; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 32);
				gap = bursty ? $urandom_range(0, 12) : 0;
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			burst_left--;
			restart = 1'b0;
			db = int'(tuner_cfg.deadband_mv);
			case ($urandom_range(0, 19))
				0: begin
					restart = with_restart;
					meas = MEAS_W'($urandom);
				end
				1: meas = MEAS_W'($urandom_range(995, 1005));
				2: meas = ($urandom_range(0, 1) != 0) ? '1 : '0;
				3, 4, 5: meas = MEAS_W'($urandom);
				default: begin
					level = int'(tuner_cfg.target_mv) + int'($urandom_range(0, 2 * db + 60))
						- db - 30;
					meas = (level < 0) ? '0 : MEAS_W'(level);
				end
			endcase
			send_tick(meas, restart, 1'b0, NO_REQ);
		end
	endtask

	// Compare each request item with the oldest prediction
	always @(posedge clk) begin : check_requests
		request_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_requests.size() == 0) begin
				$error("unexpected request item: req_volt_mv %0d converged %0b",
					m_tdata, m_tuser[0]);
				mismatches++;
			end else begin
				want = pending_requests.pop_front();
				if (m_tdata !== want.req_volt_mv) begin
					$error("req_volt_mv: expected %0d, got %0d", want.req_volt_mv, m_tdata);
					mismatches++;
				end
				if (m_tuser[0] !== want.converged) begin
					$error("converged: expected %0b, got %0b", want.converged, m_tuser[0]);
					mismatches++;
				end
			end
		end
	end

	// Receiver: switch among stall patterns, or hold off for a long stretch on request
	initial begin : request_sink
		rx_mode_t mode;
		int       mode_left;
		int       period;
		int       beat;
		int       hold_off_seen;
		m_tready      = 1'b0;
		mode          = RX_FREE;
		mode_left     = 0;
		period        = 2;
		beat          = 0;
		hold_off_seen = 0;
		forever begin
			@(negedge clk);
			if (hold_off_reqs != hold_off_seen) begin
				hold_off_seen = hold_off_reqs;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(32, 400);
					period    = $urandom_range(2, 7);
				end
				mode_left--;
				beat++;
				case (mode)
					RX_FREE:     m_tready <= 1'b1;
					RX_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
					RX_PERIODIC: m_tready <= ((beat % period) != 0);
					default:     m_tready <= 1'b1;
				endcase
			end
		end
	end

	// Count cycles with no handshake on any port
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= STALL_LIMIT);
		$display("FAIL pps_keepalive_auto_tuner_unit");
		$finish;
	end

	initial begin : stimulus
		reg_idx_t idx;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		tuner_cfg    = '0;
		tuner_cfg.refresh_interval_ticks = INTV_W'(1);
		corr_mv      = 0;
		conv_flag    = 1'b0;
		tick_count   = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rows
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				drain_stream();
				apb_write(directed_rows[i].idx, directed_rows[i].value);
			end else begin
				send_tick(directed_rows[i].value[MEAS_W-1:0], directed_rows[i].restart,
					directed_rows[i].typed, directed_rows[i].want);
			end
		end

		// Random phases, each with a fresh register setting
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain_stream();
			idx = idx.first();
			do begin
				apb_write(idx, pick_reg_value(idx));
				idx = idx.next();
			end while (idx != idx.first());
			if (ph == 2) begin
				// Dense requests while the receiver holds off: fill the pipeline
				apb_write(REG_TARGET, 32'd12000);
				apb_write(REG_REFRESH, 32'd1);
				hold_off_reqs++;
			end
			send_random_ticks(PHASE_ITEMS, (ph % 3) != 0, 1'b1);
		end

		// Let the tick count run past the interval with keep-alive off, then enable
		drain_stream();
		apb_write(REG_TARGET, 32'd0);
		apb_write(REG_REFRESH, 32'd25);
		apb_write(REG_RANGE_MIN, 32'd0);
		apb_write(REG_RANGE_MAX, 32'd32767);
		send_random_ticks(40, 1'b0, 1'b0);
		drain_stream();
		apb_write(REG_TARGET, 32'd23456);
		send_random_ticks(4, 1'b1, 1'b0);
		drain_stream();

		if (mismatches == 0)
			$display("PASS pps_keepalive_auto_tuner_unit");
		else
			$display("FAIL pps_keepalive_auto_tuner_unit");
		$finish;
	end

endmodule
